// ===== src/quic_initial_packet_builder_defines.svh =====
// Assertion macros shared by the QUIC Initial packet builder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef QUIC_INITIAL_PACKET_BUILDER_DEFINES_SVH
`define QUIC_INITIAL_PACKET_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define QIPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qipb: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define QIPB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qipb: next-cycle check failed");

`endif

// ===== src/qipb_pkg.sv =====
// Shared types, constants and the ClientHello ROM for the QUIC Initial builder.
// No dependencies; used by qipb_ctrl, qipb_dp and the top level.
package qipb_pkg;

    // Default parameter values
    localparam int HELLO_BYTES_DEF = 125;
    localparam int MAX_ID_DEF      = 20;

    // Fixed header bytes besides the two connection IDs
    localparam int FIXED_BYTES = 14;

    // Field widths
    localparam int ROOM_W = 11;
    localparam int ID_W   = 5;
    localparam int VER_W  = 32;
    localparam int CFG_IDX_W = 2;

    // Register indices on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_ID_LEN = 2'd0,
        REG_SRC_ID_LEN  = 2'd1,
        REG_VERSION     = 2'd2
    } cfg_reg_t;

    // Register reset values
    localparam logic [ID_W-1:0]  DEFAULT_ID_LEN = 5'd8;
    localparam logic [VER_W-1:0] VERSION_1      = 32'h0000_0001;

    // Byte constants of the packet
    localparam logic [7:0] LONG_HDR_BYTE = 8'hC0;
    localparam logic [7:0] DEST_MUL      = 8'h2A;
    localparam logic [7:0] DEST_ADD      = 8'h83;
    localparam logic [7:0] SRC_MUL       = 8'h5F;
    localparam logic [7:0] SRC_ADD       = 8'h11;
    localparam logic [7:0] CRYPTO_TYPE   = 8'h06;
    localparam logic [7:0] VARINT2_MARK  = 8'h40;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture room and config
        logic size;    // work out ClientHello length and room check
        logic total;   // work out packet length, rewind word pointer
        logic emit;    // put out one payload word
        logic flag;    // put out the too-small result
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic too_small;
        logic last_word;
    } ctl_sts_t;

    // ClientHello ROM, 125 bytes; anything beyond reads as zero
    function automatic logic [7:0] hello_byte(input logic [10:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            11'd0:   b = 8'h16;
            11'd1:   b = 8'h03;
            11'd2:   b = 8'h01;
            11'd4:   b = 8'h78;
            11'd5:   b = 8'h01;
            11'd8:   b = 8'h74;
            11'd9:   b = 8'h03;
            11'd10:  b = 8'h03;
            11'd45:  b = 8'h02;
            11'd46:  b = 8'h13;
            11'd47:  b = 8'h01;
            11'd48:  b = 8'h01;
            11'd51:  b = 8'h49;
            11'd55:  b = 8'h14;
            11'd57:  b = 8'h12;
            11'd60:  b = 8'h0B;
            11'd61:  b = 8'h62;
            11'd62:  b = 8'h6C;
            11'd63:  b = 8'h65;
            11'd64:  b = 8'h73;
            11'd65:  b = 8'h73;
            11'd66:  b = 8'h2E;
            11'd67:  b = 8'h6C;
            11'd68:  b = 8'h6F;
            11'd69:  b = 8'h63;
            11'd70:  b = 8'h61;
            11'd71:  b = 8'h6C;
            11'd73:  b = 8'h2B;
            11'd75:  b = 8'h03;
            11'd76:  b = 8'h02;
            11'd77:  b = 8'h03;
            11'd78:  b = 8'h04;
            11'd80:  b = 8'h33;
            11'd82:  b = 8'h26;
            11'd84:  b = 8'h24;
            11'd86:  b = 8'h1D;
            11'd88:  b = 8'h20;
            11'd122: b = 8'h39;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== src/qipb_ctrl.sv =====
// Sequencing state machine of the QUIC Initial builder.
// Depends on qipb_pkg; drives qipb_dp through ctl_cmd_t / ctl_sts_t.
`include "quic_initial_packet_builder_defines.svh"

module qipb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  qipb_pkg::ctl_sts_t sts,
    output qipb_pkg::ctl_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SIZE  = 4'b0010,
        ST_TOTAL = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                cmd.size   = 1'b1;
                state_next = ST_TOTAL;
            end
            ST_TOTAL:
            begin
                if (sts.too_small)
                begin
                    cmd.flag   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.total  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.last_word)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // Checks
    `QIPB_ASSERT_NXT(a_load_then_size, clk, rst_n, cmd.load, cmd.size)
    `QIPB_ASSERT_NXT(a_size_then_decide, clk, rst_n, cmd.size, cmd.total || cmd.flag)
    `QIPB_ASSERT_NXT(a_flag_then_free, clk, rst_n, cmd.flag, !busy)
    `QIPB_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule

// ===== src/qipb_dp.sv =====
// Datapath of the QUIC Initial builder: config registers, length arithmetic,
// eight byte lanes and the result register. Depends on qipb_pkg.
`include "quic_initial_packet_builder_defines.svh"

module qipb_dp
#(
    parameter int HELLO_BYTES   = qipb_pkg::HELLO_BYTES_DEF,
    parameter int MAX_ID_LENGTH = qipb_pkg::MAX_ID_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [qipb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qipb_pkg::VER_W-1:0]          cfg_data,
    input  logic [qipb_pkg::ROOM_W-1:0]         room,
    input  qipb_pkg::ctl_cmd_t                  cmd,
    output qipb_pkg::ctl_sts_t                  sts,
    output logic                                result_valid,
    output logic [63:0]                         word,
    output logic [3:0]                          byte_count,
    output logic                                last,
    output logic                                too_small,
    output logic [7:0]                          packet_bytes
);

    localparam int ID_CAP  = (MAX_ID_LENGTH > 8) ? MAX_ID_LENGTH : 8;
    localparam int PKT_MAX = qipb_pkg::FIXED_BYTES + 2 * ID_CAP + HELLO_BYTES;
    localparam int PW      = $clog2(PKT_MAX + 8);
    localparam int NW      = $clog2(HELLO_BYTES + 1);
    localparam int RW      = qipb_pkg::ROOM_W;

    // Configuration registers
    logic [qipb_pkg::ID_W-1:0]  dest_len_reg;
    logic [qipb_pkg::ID_W-1:0]  src_len_reg;
    logic [qipb_pkg::VER_W-1:0] version_reg;

    // Per-packet working registers
    logic [RW-1:0]              room_reg;
    logic [qipb_pkg::ID_W-1:0]  d_reg;
    logic [qipb_pkg::ID_W-1:0]  s_reg;
    logic [qipb_pkg::VER_W-1:0] ver_reg;
    logic [PW-1:0]              hdr_reg;
    logic [PW-1:0]              tok_reg;
    logic [NW-1:0]              n_reg;
    logic                       small_reg;
    logic [PW-1:0]              total_reg;
    logic [PW-1:0]              base_reg;
    logic [15:0]                lenv_reg;
    logic [15:0]                clen_reg;

    // Result registers
    logic        out_valid_reg;
    logic [63:0] word_reg;
    logic [3:0]  count_reg;
    logic        last_reg;
    logic        small_out_reg;
    logic [7:0]  total_out_reg;

    logic [qipb_pkg::ID_W-1:0] eff_d;
    logic [qipb_pkg::ID_W-1:0] eff_s;
    logic [RW:0]               diff;
    logic [15:0]               nplus;
    logic [15:0]               nwide;
    logic [PW-1:0]             rem;
    logic                      last_word;
    logic [3:0]                count_next;
    logic [7:0]                lane [8];
    logic [63:0]               word_next;

    // 0 selects the default, larger values clamp to the maximum
    function automatic logic [qipb_pkg::ID_W-1:0] eff_len(input logic [qipb_pkg::ID_W-1:0] v);
        logic [qipb_pkg::ID_W-1:0] r;
        if (v == '0)
        begin
            r = qipb_pkg::DEFAULT_ID_LEN;
        end
        else if (v > qipb_pkg::ID_W'(MAX_ID_LENGTH))
        begin
            r = qipb_pkg::ID_W'(MAX_ID_LENGTH);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Payload byte at position p of the current packet
    function automatic logic [7:0] byte_at(input logic [PW-1:0] p);
        logic [PW-1:0] s_pos;
        logic [PW-1:0] di;
        logic [PW-1:0] si;
        logic [PW-1:0] hi;
        logic [PW-1:0] ti;
        logic [7:0]    b;
        s_pos = PW'(6) + PW'(d_reg);
        di    = p - PW'(6);
        si    = p - (s_pos + PW'(1));
        hi    = p - hdr_reg;
        ti    = p - tok_reg;
        b     = 8'h00;
        if (p < PW'(5))
        begin
            case (p[2:0])
                3'd0:    b = qipb_pkg::LONG_HDR_BYTE;
                3'd1:    b = ver_reg[31:24];
                3'd2:    b = ver_reg[23:16];
                3'd3:    b = ver_reg[15:8];
                3'd4:    b = ver_reg[7:0];
                default: b = 8'h00;
            endcase
        end
        else if (p == PW'(5))
        begin
            b = 8'(d_reg);
        end
        else if (p < s_pos)
        begin
            b = 8'(di) * qipb_pkg::DEST_MUL + qipb_pkg::DEST_ADD;
        end
        else if (p == s_pos)
        begin
            b = 8'(s_reg);
        end
        else if (p < tok_reg)
        begin
            b = 8'(si) * qipb_pkg::SRC_MUL + qipb_pkg::SRC_ADD;
        end
        else if (p < hdr_reg)
        begin
            // token length, Length varint, CRYPTO type, offset, CRYPTO length
            case (ti[2:0])
                3'd1:    b = lenv_reg[15:8];
                3'd2:    b = lenv_reg[7:0];
                3'd3:    b = qipb_pkg::CRYPTO_TYPE;
                3'd5:    b = clen_reg[15:8];
                3'd6:    b = clen_reg[7:0];
                default: b = 8'h00;
            endcase
        end
        else
        begin
            b = qipb_pkg::hello_byte(11'(hi));
        end
        return b;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_len_reg <= qipb_pkg::DEFAULT_ID_LEN;
            src_len_reg  <= qipb_pkg::DEFAULT_ID_LEN;
            version_reg  <= qipb_pkg::VERSION_1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                qipb_pkg::REG_DEST_ID_LEN: dest_len_reg <= cfg_data[qipb_pkg::ID_W-1:0];
                qipb_pkg::REG_SRC_ID_LEN:  src_len_reg  <= cfg_data[qipb_pkg::ID_W-1:0];
                qipb_pkg::REG_VERSION:     version_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Length arithmetic
    assign eff_d = eff_len(dest_len_reg);
    assign eff_s = eff_len(src_len_reg);
    assign diff  = {1'b0, room_reg} - (RW + 1)'(hdr_reg);
    assign nwide = 16'(n_reg);
    assign nplus = nwide + 16'd4;
    assign rem   = total_reg - base_reg;
    assign last_word  = (rem <= PW'(8));
    assign count_next = last_word ? rem[3:0] : 4'd8;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            room_reg <= room;
            d_reg    <= eff_d;
            s_reg    <= eff_s;
            ver_reg  <= (version_reg == '0) ? qipb_pkg::VERSION_1 : version_reg;
            hdr_reg  <= PW'(qipb_pkg::FIXED_BYTES) + PW'(eff_d) + PW'(eff_s);
            tok_reg  <= PW'(qipb_pkg::FIXED_BYTES - 7) + PW'(eff_d) + PW'(eff_s);
        end
        if (cmd.size)
        begin
            small_reg <= diff[RW];
            n_reg     <= (diff[RW-1:0] > RW'(HELLO_BYTES)) ? NW'(HELLO_BYTES)
                                                          : NW'(diff[RW-1:0]);
        end
        if (cmd.total)
        begin
            total_reg <= hdr_reg + PW'(n_reg);
            lenv_reg  <= {qipb_pkg::VARINT2_MARK | {2'b00, nplus[13:8]}, nplus[7:0]};
            clen_reg  <= {qipb_pkg::VARINT2_MARK | {2'b00, nwide[13:8]}, nwide[7:0]};
            base_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            base_reg <= base_reg + PW'(8);
        end
    end

    // Eight byte lanes, unused tail bytes forced to zero
    always_comb
    begin
        for (int l = 0; l < 8; l++)
        begin
            lane[l] = (4'(l) < count_next) ? byte_at(base_reg + PW'(l)) : 8'h00;
        end
        word_next = {lane[0], lane[1], lane[2], lane[3],
                     lane[4], lane[5], lane[6], lane[7]};
    end

    // Result register: strobe is cleared by reset, payload is not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit || cmd.flag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flag)
        begin
            word_reg      <= '0;
            count_reg     <= '0;
            last_reg      <= 1'b1;
            small_out_reg <= 1'b1;
            total_out_reg <= '0;
        end
        else if (cmd.emit)
        begin
            word_reg      <= word_next;
            count_reg     <= count_next;
            last_reg      <= last_word;
            small_out_reg <= 1'b0;
            total_out_reg <= last_word ? 8'(total_reg) : 8'h00;
        end
    end

    assign sts.too_small = small_reg;
    assign sts.last_word = last_word;

    assign result_valid = out_valid_reg;
    assign word         = word_reg;
    assign byte_count   = count_reg;
    assign last         = last_reg;
    assign too_small    = small_out_reg;
    assign packet_bytes = total_out_reg;

    // Checks
    `QIPB_ASSERT_IMP(a_full_middle, clk, rst_n, out_valid_reg && !last_reg, count_reg == 4'd8)
    `QIPB_ASSERT_IMP(a_small_empty, clk, rst_n, out_valid_reg && small_out_reg,
                     word_reg == 64'd0 && count_reg == 4'd0 && last_reg)
    `QIPB_ASSERT_IMP(a_data_nonempty, clk, rst_n, out_valid_reg && !small_out_reg, count_reg != 4'd0)
    `QIPB_ASSERT_NXT(a_gap_after_last, clk, rst_n, out_valid_reg && last_reg, !out_valid_reg)

endmodule

// ===== src/quic_initial_packet_builder.sv =====
// Top level of the QUIC v1 Initial payload builder.
// Depends on qipb_pkg, qipb_ctrl and qipb_dp.
//
//  channel   | handshake                | beat contents
//  ----------+--------------------------+-----------------------------------------
//  request   | start / busy             | room
//  config    | cfg_valid / cfg_ready    | cfg_index, cfg_data
//  result    | result_valid (strobe)    | word, byte_count, last, too_small,
//            |                          | packet_bytes
//
// A request of T payload bytes gives ceil(T/8) result beats, one per cycle, and
// busy drops with the last one, also for a too-small room. The beats follow the
// size and total length-arithmetic states and come from the one-word-per-cycle
// byte lanes.
// Reset is asynchronous, active low; it restores the register defaults.
// Results cannot be held off; cfg_ready is always high.

module quic_initial_packet_builder
#(
    parameter int HELLO_BYTES   = qipb_pkg::HELLO_BYTES_DEF,
    parameter int MAX_ID_LENGTH = qipb_pkg::MAX_ID_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [qipb_pkg::ROOM_W-1:0]     room,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qipb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qipb_pkg::VER_W-1:0]      cfg_data,
    output logic                            result_valid,
    output logic [63:0]                     word,
    output logic [3:0]                      byte_count,
    output logic                            last,
    output logic                            too_small,
    output logic [7:0]                      packet_bytes
);

    qipb_pkg::ctl_cmd_t cmd;
    qipb_pkg::ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer
    qipb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Datapath
    qipb_dp
    #(
        .HELLO_BYTES   (HELLO_BYTES),
        .MAX_ID_LENGTH (MAX_ID_LENGTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .room         (room),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .word         (word),
        .byte_count   (byte_count),
        .last         (last),
        .too_small    (too_small),
        .packet_bytes (packet_bytes)
    );

endmodule

// ===== test/qipb_checker.sv =====
// Scoreboard for the QUIC Initial payload builder: watches the request, config
// and result channels, predicts every payload beat and compares field by field.
// Depends on qipb_pkg for widths, register indices and byte constants.
module qipb_checker
    import qipb_pkg::*;
#(
    parameter int HELLO_BYTES   = HELLO_BYTES_DEF,
    parameter int MAX_ID_LENGTH = MAX_ID_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [ROOM_W-1:0]     room,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VER_W-1:0]      cfg_data,
    input  logic                  result_valid,
    input  logic [63:0]           word,
    input  logic [3:0]            byte_count,
    input  logic                  last,
    input  logic                  too_small,
    input  logic [7:0]            packet_bytes,
    output int                    fail_count,
    output int                    pending,
    output int                    beats
);

    localparam int PKT_MAX = FIXED_BYTES + 2 * MAX_ID_LENGTH + HELLO_BYTES;
    localparam int ROM_LEN = 125;

    // ClientHello image, byte 0 in the top bits
    localparam logic [8*ROM_LEN-1:0] HELLO_IMAGE = {
        88'h16_03_01_00_78_01_00_00_74_03_03,
        256'h0,
        72'h00_00_02_13_01_01_00_00_49,
        72'h00_00_00_14_00_12_00_00_0B,
        88'h62_6C_65_73_73_2E_6C_6F_63_61_6C,
        56'h00_2B_00_03_02_03_04,
        80'h00_33_00_26_00_24_00_1D_00_20,
        256'h0,
        32'h00_39_00_00
    };

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  byte_count;
        logic        last;
        logic        too_small;
        logic [7:0]  packet_bytes;
    } payload_beat_t;

    payload_beat_t   expected_beats[$];
    logic [ID_W-1:0] dest_len_q;
    logic [ID_W-1:0] src_len_q;
    logic [VER_W-1:0] version_q;

    // Effective connection ID length: zero means default, large values capped
    function automatic int id_bytes(input logic [ID_W-1:0] v);
        if (v == '0)
            return 8;
        if (int'(v) > MAX_ID_LENGTH)
            return MAX_ID_LENGTH;
        return int'(v);
    endfunction

    function automatic logic [7:0] hello_at(input int i);
        if (i < ROM_LEN)
            return HELLO_IMAGE[8*(ROM_LEN-1-i) +: 8];
        return 8'h00;
    endfunction

    // Build the payload for one request and queue its beats
    task automatic predict_packet(input logic [ROOM_W-1:0] room_b);
        logic [7:0]       pkt [0:PKT_MAX-1];
        logic [VER_W-1:0] ver;
        logic [15:0]      len2;
        logic [63:0]      w;
        payload_beat_t    b;
        int d, s, hdr, n, p, total, words, cnt;
        d   = id_bytes(dest_len_q);
        s   = id_bytes(src_len_q);
        ver = (version_q == '0) ? VERSION_1 : version_q;
        hdr = FIXED_BYTES + d + s;
        if (int'(room_b) < hdr)
        begin
            b = '{word: '0, byte_count: '0, last: 1'b1, too_small: 1'b1, packet_bytes: '0};
            expected_beats.push_back(b);
            return;
        end
        n = int'(room_b) - hdr;
        if (n > HELLO_BYTES)
            n = HELLO_BYTES;

        // header, IDs, token length
        p = 0;
        pkt[p] = LONG_HDR_BYTE;  p = p + 1;
        pkt[p] = ver[31:24];     p = p + 1;
        pkt[p] = ver[23:16];     p = p + 1;
        pkt[p] = ver[15:8];      p = p + 1;
        pkt[p] = ver[7:0];       p = p + 1;
        pkt[p] = 8'(d);          p = p + 1;
        for (int i = 0; i < d; i++)
        begin
            pkt[p] = 8'(i * DEST_MUL + DEST_ADD);
            p = p + 1;
        end
        pkt[p] = 8'(s);          p = p + 1;
        for (int i = 0; i < s; i++)
        begin
            pkt[p] = 8'(i * SRC_MUL + SRC_ADD);
            p = p + 1;
        end
        pkt[p] = 8'h00;          p = p + 1;

        // Length varint, CRYPTO frame header, ClientHello
        len2 = 16'(n + 4);
        pkt[p] = VARINT2_MARK | {2'b00, len2[13:8]};  p = p + 1;
        pkt[p] = len2[7:0];                           p = p + 1;
        pkt[p] = CRYPTO_TYPE;    p = p + 1;
        pkt[p] = 8'h00;          p = p + 1;
        len2 = 16'(n);
        pkt[p] = VARINT2_MARK | {2'b00, len2[13:8]};  p = p + 1;
        pkt[p] = len2[7:0];                           p = p + 1;
        for (int i = 0; i < n; i++)
        begin
            pkt[p] = hello_at(i);
            p = p + 1;
        end

        // slice into 8-byte words
        total = p;
        words = (total + 7) / 8;
        for (int k = 0; k < words; k++)
        begin
            cnt = total - 8 * k;
            if (cnt > 8)
                cnt = 8;
            w = '0;
            for (int i = 0; i < cnt; i++)
                w[63-8*i -: 8] = pkt[8*k + i];
            b.word         = w;
            b.byte_count   = 4'(cnt);
            b.last         = (k == words - 1);
            b.too_small    = 1'b0;
            b.packet_bytes = b.last ? 8'(total) : 8'h00;
            expected_beats.push_back(b);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        payload_beat_t exp_b;
        int errs;
        if (!rst_n)
        begin
            dest_len_q <= DEFAULT_ID_LEN;
            src_len_q  <= DEFAULT_ID_LEN;
            version_q  <= VERSION_1;
            expected_beats.delete();
            fail_count <= 0;
            pending    <= 0;
            beats      <= 0;
        end
        else
        begin
            errs = 0;

            // register writes; unknown indices are dropped
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DEST_ID_LEN)
                    dest_len_q <= cfg_data[ID_W-1:0];
                else if (cfg_index == REG_SRC_ID_LEN)
                    src_len_q <= cfg_data[ID_W-1:0];
                else if (cfg_index == REG_VERSION)
                    version_q <= cfg_data;
            end

            // compare a result beat with the oldest expectation
            if (result_valid)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: word %h", word);
                    errs = errs + 1;
                end
                else
                begin
                    exp_b = expected_beats.pop_front();
                    if (word !== exp_b.word)
                    begin
                        $error("word: expected %h, got %h", exp_b.word, word);
                        errs = errs + 1;
                    end
                    if (byte_count !== exp_b.byte_count)
                    begin
                        $error("byte_count: expected %0d, got %0d",
                               exp_b.byte_count, byte_count);
                        errs = errs + 1;
                    end
                    if (last !== exp_b.last)
                    begin
                        $error("last: expected %b, got %b", exp_b.last, last);
                        errs = errs + 1;
                    end
                    if (too_small !== exp_b.too_small)
                    begin
                        $error("too_small: expected %b, got %b", exp_b.too_small, too_small);
                        errs = errs + 1;
                    end
                    if (packet_bytes !== exp_b.packet_bytes)
                    begin
                        $error("packet_bytes: expected %0d, got %0d",
                               exp_b.packet_bytes, packet_bytes);
                        errs = errs + 1;
                    end
                end
                beats <= beats + 1;
            end

            // new request beat
            if (start && !busy)
                predict_packet(room);

            fail_count <= fail_count + errs;
            pending    <= expected_beats.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the QUIC Initial payload builder bench: clock, reset, request and
// config stimulus, timeout and verdict. Depends on qipb_pkg, the builder RTL
// and qipb_checker, which does all prediction and comparison.
module testbench;
    import qipb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [ROOM_W-1:0]    room = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VER_W-1:0]     cfg_data = '0;
    logic                 result_valid;
    logic [63:0]          word;
    logic [3:0]           byte_count;
    logic                 last;
    logic                 too_small;
    logic [7:0]           packet_bytes;

    int fail_count;
    int pending;
    int beats;
    int cycles = 0;
    int requests = 0;
    int settings = 0;

    quic_initial_packet_builder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .room         (room),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .word         (word),
        .byte_count   (byte_count),
        .last         (last),
        .too_small    (too_small),
        .packet_bytes (packet_bytes)
    );

    qipb_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .room         (room),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .word         (word),
        .byte_count   (byte_count),
        .last         (last),
        .too_small    (too_small),
        .packet_bytes (packet_bytes),
        .fail_count   (fail_count),
        .pending      (pending),
        .beats        (beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one request beat, then, at random, a pause with start low
    task automatic send_request(input logic [ROOM_W-1:0] r, input int idle_pct);
        start <= 1'b1;
        room  <= r;
        do @(posedge clk); while (busy);
        requests++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // stop requesting, then wait until every expected beat is back and the block is free
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [VER_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // full register set plus a write to the unused index
    task automatic apply_settings(input logic [VER_W-1:0] dest_d,
                                  input logic [VER_W-1:0] src_d,
                                  input logic [VER_W-1:0] ver_d);
        wait_idle();
        cfg_beat(REG_DEST_ID_LEN, dest_d);
        cfg_beat(REG_SRC_ID_LEN, src_d);
        cfg_beat(REG_VERSION, ver_d);
        cfg_beat(REG_SPARE, $urandom());
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [ROOM_W-1:0] random_room();
        if ($urandom_range(99) < 70)
            return ROOM_W'($urandom_range(0, 200));
        return ROOM_W'($urandom_range(0, 2047));
    endfunction

    initial
    begin : stimulus
        int idle_pct [4];
        logic [VER_W-1:0] ver_d;
        idle_pct = '{0, 68, 0, 10};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults, header of 30 bytes: empty, boundary, full, huge rooms
        send_request(11'd0, 0);
        send_request(11'd29, 0);
        send_request(11'd30, 0);
        send_request(11'd31, 0);
        send_request(11'd32, 0);
        send_request(11'd154, 0);
        send_request(11'd155, 0);
        send_request(11'd156, 0);
        send_request(11'h555, 0);
        send_request(11'h2AA, 0);
        send_request(11'd2047, 0);

        // shortest IDs, version zero selects version 1
        apply_settings(32'd1, 32'd1, 32'd0);
        send_request(11'd15, 0);
        send_request(11'd16, 0);
        send_request(11'd17, 0);
        send_request(11'd141, 0);

        // longest IDs, all-ones version
        apply_settings(32'd20, 32'd20, 32'hFFFF_FFFF);
        send_request(11'd53, 0);
        send_request(11'd54, 0);
        send_request(11'd179, 0);
        send_request(11'd180, 0);

        // upper bits ignored, zero length defaults, over-range lengths capped
        apply_settings(32'hFFFF_FFE0, 32'h0000_001F, $urandom());
        send_request(11'd41, 0);
        send_request(11'd42, 0);
        send_request(11'd1024, 0);
        apply_settings(32'd21, 32'd0, 32'h8000_0000);
        send_request(11'd44, 0);
        send_request(11'd169, 0);

        // random phases, each under fresh random settings
        for (int ph = 0; ph < 4; ph++)
        begin
            ver_d = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
            apply_settings($urandom(), $urandom(), ver_d);
            for (int i = 0; i < 40; i++)
                send_request(random_room(), idle_pct[ph]);
        end

        start <= 1'b0;
        wait_idle();
        repeat (5) @(posedge clk);

        $display("Covered %0d requests under %0d register settings, %0d payload beats checked.",
                 requests, settings + 1, beats);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/qipb_pkg.sv
src/qipb_ctrl.sv
src/qipb_dp.sv
src/quic_initial_packet_builder.sv
test/qipb_checker.sv
test/testbench.sv
